// ----- design/kst_pkg.sv -----
`timescale 1ns / 1ps

package kst_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int ID_W         = 64;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 4;
    localparam int PADDR_W      = 4;

    localparam logic [ID_W-1:0] ID_MAX = '1;

    localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
    localparam logic [OP_W-1:0] OP_FREEZE  = 3'd2;
    localparam logic [OP_W-1:0] OP_VERIFY  = 3'd3;
    localparam logic [OP_W-1:0] OP_FINISH  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK         = 4'd0;
    localparam logic [STAT_W-1:0] ST_NULL_KEY   = 4'd1;
    localparam logic [STAT_W-1:0] ST_FROZEN     = 4'd2;
    localparam logic [STAT_W-1:0] ST_ID_DONE    = 4'd3;
    localparam logic [STAT_W-1:0] ST_UNKNOWN    = 4'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FROZEN = 4'd5;
    localparam logic [STAT_W-1:0] ST_EMIT_DONE  = 4'd6;
    localparam logic [STAT_W-1:0] ST_MISMATCH   = 4'd7;
    localparam logic [STAT_W-1:0] ST_ORDER      = 4'd8;
    localparam logic [STAT_W-1:0] ST_NOT_ALL    = 4'd9;
    localparam logic [STAT_W-1:0] ST_FULL       = 4'd10;

    // register index of first_id on the config port
    localparam logic REG_FIRST_ID = 1'b0;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

    function automatic int addr_w(input int cap);
        return (cap > 1) ? $clog2(cap) : 1;
    endfunction

endpackage

// ----- design/kst_scan.sv -----
`timescale 1ns / 1ps

module kst_scan #(
    parameter int   CAPACITY = kst_pkg::DEF_CAPACITY,
    localparam int  AW       = kst_pkg::addr_w(CAPACITY),
    localparam int  CW       = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_scan_start,
    input  logic [kst_pkg::ID_W-1:0]  i_key,
    input  logic [CW-1:0]             i_count,
    input  logic                      i_wr_en,
    input  logic [kst_pkg::ID_W-1:0]  i_wr_data,
    output kst_pkg::t_scan_stat       o_stat,
    output logic [AW-1:0]             o_slot
);
    import kst_pkg::*;

    logic [ID_W-1:0] r_mem [CAPACITY];
    logic [ID_W-1:0] r_rdata;
    logic            r_busy;
    logic [CW-1:0]   r_rd_idx;
    logic            r_cmp_vld;
    logic [AW-1:0]   r_cmp_idx;

    logic            w_hit;
    logic            w_done;
    logic            w_rd_en;
    logic [AW-1:0]   w_addr;

    assign w_hit   = r_busy && r_cmp_vld && (r_rdata == i_key);
    assign w_done  = r_busy && (w_hit || (r_rd_idx == i_count));
    assign w_rd_en = r_busy && !w_done;
    // one port: a write comes only in the cycle a scan finishes, when no read is issued
    assign w_addr  = i_wr_en ? i_count[AW-1:0] : r_rd_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[w_addr] <= i_wr_data;
        end else if (w_rd_en) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
        end else if (i_scan_start) begin
            r_busy    <= 1'b1;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (w_done) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else if (w_rd_en) begin
            r_rd_idx  <= r_rd_idx + 1'b1;
            r_cmp_vld <= 1'b1;
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
    end

    assign o_stat.done = w_done;
    assign o_stat.hit  = w_hit;
    assign o_slot      = r_cmp_idx;

endmodule

// ----- design/key_to_sequential_id_table.sv -----
`timescale 1ns / 1ps

// Key interning table: maps nonzero 64-bit keys to sequential IDs.
// Request channel: drive i_op, i_key and i_claimed_id with i_start; the request
// is taken at a rising edge where i_start is high and o_busy is low.
// Result channel: o_valid pulses for one cycle with o_id_out and o_status.
// The receiver cannot stall; every request yields exactly one result.
// Freeze, finish, unused ops and early errors answer in the cycle after the
// request. Reserve, lookup and verify scan the stored keys through a single
// port memory with a registered read, one key per cycle, comparing at most
// entry_count keys. o_busy stays high during the scan; the next request is
// taken in the cycle the result is shown.
// Config: APB-style port, first_id at byte address 0; writes take effect only
// while the table is empty and nothing has been emitted.
// Reset (synchronous, active low) empties the table and clears first_id and
// all counters and flags; no memory clearing pass is needed.
module key_to_sequential_id_table #(
    parameter int CAPACITY = kst_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [kst_pkg::OP_W-1:0]     i_op,
    input  logic [kst_pkg::ID_W-1:0]     i_key,
    input  logic [kst_pkg::ID_W-1:0]     i_claimed_id,
    output logic                         o_valid,
    output logic [kst_pkg::ID_W-1:0]     o_id_out,
    output logic [kst_pkg::STAT_W-1:0]   o_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kst_pkg::PADDR_W-1:0]  paddr,
    input  logic [kst_pkg::ID_W-1:0]     pwdata,
    output logic [kst_pkg::ID_W-1:0]     prdata,
    output logic                         pready
);
    import kst_pkg::*;

    localparam int AW = addr_w(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state          r_state;
    logic [OP_W-1:0] r_op;
    logic [ID_W-1:0] r_key;
    logic [ID_W-1:0] r_claimed;

    logic [ID_W-1:0] r_first_id;
    logic [ID_W-1:0] r_next_free_id;
    logic [ID_W-1:0] r_next_emit_id;
    logic [CW-1:0]   r_entry_count;
    logic [CW-1:0]   r_emitted_total;
    logic            r_id_done;
    logic            r_emit_done;
    logic            r_frozen;

    logic              r_valid;
    logic [ID_W-1:0]   r_id_out;
    logic [STAT_W-1:0] r_status;

    logic            w_accept;
    logic            w_cfg_wr;
    logic            w_need_scan;
    logic            w_wr_en;
    logic [ID_W-1:0] w_scan_id;
    t_scan_stat      w_scan;
    logic [AW-1:0]   w_slot;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_FIRST_ID);

    always_comb begin
        w_need_scan = 1'b0;
        case (i_op)
            OP_RESERVE, OP_LOOKUP: w_need_scan = (i_key != '0);
            OP_VERIFY:             w_need_scan = (i_key != '0) && r_frozen && !r_emit_done;
            default:               w_need_scan = 1'b0;
        endcase
    end

    assign w_scan_id = r_first_id + {{(ID_W-AW){1'b0}}, w_slot};

    // store the new key in the cycle the scan reports a miss
    assign w_wr_en = (r_state == S_SCAN) && w_scan.done && !w_scan.hit
                     && (r_op == OP_RESERVE) && !r_frozen && !r_id_done
                     && (r_entry_count != CW'(CAPACITY));

    kst_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_start (w_accept && w_need_scan),
        .i_key        (r_state == S_SCAN ? r_key : i_key),
        .i_count      (r_entry_count),
        .i_wr_en      (w_wr_en),
        .i_wr_data    (r_key),
        .o_stat       (w_scan),
        .o_slot       (w_slot)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_op;
            r_key     <= i_key;
            r_claimed <= i_claimed_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_first_id      <= '0;
            r_next_free_id  <= '0;
            r_next_emit_id  <= '0;
            r_entry_count   <= '0;
            r_emitted_total <= '0;
            r_id_done       <= 1'b0;
            r_emit_done     <= 1'b0;
            r_frozen        <= 1'b0;
            r_valid         <= 1'b0;
            r_id_out        <= '0;
            r_status        <= ST_OK;
        end else begin
            r_valid <= 1'b0;
            if (w_cfg_wr && (r_entry_count == '0) && (r_emitted_total == '0)
                && !r_id_done && !r_emit_done) begin
                r_first_id     <= pwdata;
                r_next_free_id <= pwdata;
                r_next_emit_id <= pwdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_need_scan) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_valid  <= 1'b1;
                            r_id_out <= '0;
                            r_status <= ST_OK;
                            case (i_op)
                                OP_RESERVE, OP_LOOKUP: r_status <= ST_NULL_KEY;
                                OP_FREEZE: r_frozen <= 1'b1;
                                OP_VERIFY: begin
                                    if (i_key == '0) begin
                                        r_status <= ST_NULL_KEY;
                                    end else if (!r_frozen) begin
                                        r_status <= ST_NOT_FROZEN;
                                    end else begin
                                        r_status <= ST_EMIT_DONE;
                                    end
                                end
                                OP_FINISH: begin
                                    if (!r_frozen) begin
                                        r_status <= ST_NOT_FROZEN;
                                    end else if (r_entry_count != r_emitted_total) begin
                                        r_status <= ST_NOT_ALL;
                                    end
                                end
                                default: r_status <= ST_OK;
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    if (w_scan.done) begin
                        r_state  <= S_IDLE;
                        r_valid  <= 1'b1;
                        r_id_out <= '0;
                        r_status <= ST_OK;
                        if (r_op == OP_VERIFY) begin
                            if (!w_scan.hit) begin
                                r_status <= ST_UNKNOWN;
                            end else if (r_claimed != w_scan_id) begin
                                r_status <= ST_MISMATCH;
                            end else if (w_scan_id != r_next_emit_id) begin
                                r_status <= ST_ORDER;
                            end else begin
                                r_emitted_total <= r_emitted_total + 1'b1;
                                if (r_next_emit_id == ID_MAX) begin
                                    r_emit_done <= 1'b1;
                                end else begin
                                    r_next_emit_id <= r_next_emit_id + 1'b1;
                                end
                            end
                        end else if (w_scan.hit) begin
                            r_id_out <= w_scan_id;
                        end else if (r_op == OP_LOOKUP) begin
                            r_status <= ST_UNKNOWN;
                        end else if (r_frozen) begin
                            r_status <= ST_FROZEN;
                        end else if (r_id_done) begin
                            r_status <= ST_ID_DONE;
                        end else if (r_entry_count == CW'(CAPACITY)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_id_out      <= r_next_free_id;
                            r_entry_count <= r_entry_count + 1'b1;
                            if (r_next_free_id == ID_MAX) begin
                                r_id_done <= 1'b1;
                            end else begin
                                r_next_free_id <= r_next_free_id + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_id_out = r_id_out;
    assign o_status = r_status;
    assign pready   = 1'b1;
    assign prdata   = (paddr[3] == REG_FIRST_ID) ? r_first_id : '0;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted_total <= r_entry_count)
        else $error("more emissions than entries");

    a_scan_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> (r_state == S_SCAN))
        else $error("scan finished outside scan state");

    a_write_no_key_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_entry_count == $past(r_entry_count) + 1'b1) && o_valid)
        else $error("key stored without count advance");

endmodule
